@@ sv/jmse_pkg.sv @@
// shared types, codes, widths and helpers for the jackknife standard error block
package jmse_pkg;

    localparam int MAX_ITEMS_DEF = 1024;

    // datapath widths
    localparam int ACC_W  = 64;   // replicate sum Q48.16, square sum Q32.32
    localparam int TOT_W  = 48;   // ratio mode column totals
    localparam int NUM_W  = 50;   // quotient numerator and denominator
    localparam int PA_W   = 128;  // wide product / dividend
    localparam int PB_W   = 64;   // narrow multiplier operand / divisor
    localparam int ROOT_W = 32;

    // mode register codes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_DIFF  = 2'd1;
    localparam logic [1:0] MODE_RATIO = 2'd2;

    // value state codes
    localparam logic [1:0] ST_FIN  = 2'd0;
    localparam logic [1:0] ST_NAN  = 2'd1;
    localparam logic [1:0] ST_PINF = 2'd2;
    localparam logic [1:0] ST_NINF = 2'd3;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RSQ,
        S_RREAD,
        S_RNUM,
        S_DQ,
        S_DQW,
        S_STD,
        S_MA,
        S_MB,
        S_CMP,
        S_MP,
        S_MN,
        S_VDIV,
        S_SQRT,
        S_STDFIN,
        S_ZSEL,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        DQ_REP,
        DQ_EST,
        DQ_Z
    } t_dsel;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [NUM_W-1:0] mag50(input logic [NUM_W-1:0] v);
        mag50 = v[NUM_W-1] ? (~v + NUM_W'(1)) : v;
    endfunction

    function automatic logic [ACC_W-1:0] mag64(input logic [ACC_W-1:0] v);
        mag64 = v[ACC_W-1] ? (~v + ACC_W'(1)) : v;
    endfunction

endpackage

@@ sv/jmse_mul.sv @@
// multi-cycle 128x64 truncated multiplier built on one 32x32 partial product
module jmse_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [jmse_pkg::PA_W-1:0]   i_a,
    input  logic [jmse_pkg::PB_W-1:0]   i_b,
    output logic [jmse_pkg::PA_W-1:0]   o_prod,
    output logic                        o_done
);
    import jmse_pkg::*;

    logic [PA_W-1:0] r_a;
    logic [PB_W-1:0] r_b;
    logic [2:0]      r_k;
    logic            r_run;
    logic            r_ppv;
    logic            r_pplast;
    logic            r_done;
    logic [63:0]     r_pp;
    logic [2:0]      r_sh;
    logic [PA_W-1:0] r_acc;

    logic [31:0]     a_l;
    logic [31:0]     b_l;
    logic [2:0]      sh;
    logic [PA_W-1:0] pp_shift;

    // limb i of a times limb j of b, weight 2^(32*(i+j))
    assign a_l = r_a[{r_k[2:1], 5'b0} +: 32];
    assign b_l = r_b[{r_k[0], 5'b0} +: 32];
    assign sh  = {1'b0, r_k[2:1]} + {2'b0, r_k[0]};

    always_comb begin
        if (r_sh[2]) begin
            pp_shift = '0;
        end else begin
            pp_shift = {64'b0, r_pp} << {r_sh[1:0], 5'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_ppv    <= 1'b0;
            r_pplast <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= r_ppv && r_pplast;
            if (i_start) begin
                r_run <= 1'b1;
                r_ppv <= 1'b0;
            end else if (r_run) begin
                r_ppv    <= 1'b1;
                r_pplast <= (r_k == 3'd7);
                if (r_k == 3'd7) begin
                    r_run <= 1'b0;
                end
            end else begin
                r_ppv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_k   <= 3'd0;
            r_acc <= '0;
        end else begin
            if (r_ppv) begin
                r_acc <= r_acc + pp_shift;
            end
            if (r_run) begin
                r_k  <= r_k + 3'd1;
                r_pp <= 64'(a_l) * 64'(b_l);
                r_sh <= sh;
            end
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

@@ sv/jmse_div.sv @@
// restoring divider, one quotient bit per cycle, 128-bit dividend over 64-bit divisor
module jmse_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [jmse_pkg::PA_W-1:0]   i_num,
    input  logic [jmse_pkg::PB_W-1:0]   i_den,
    output logic [jmse_pkg::PA_W-1:0]   o_quo,
    output logic                        o_done
);
    import jmse_pkg::*;

    logic [PA_W-1:0]         r_dq;
    logic [PB_W-1:0]         r_rem;
    logic [PB_W-1:0]         r_den;
    logic [$clog2(PA_W)-1:0] r_cnt;
    logic                    r_run;
    logic                    r_done;

    logic [PB_W:0] rem_sh;
    logic [PB_W:0] rem_sub;
    logic          ge;

    assign rem_sh  = {r_rem, r_dq[PA_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign ge      = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && (r_cnt == '0);
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_cnt == '0)) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= '1;
        end else if (r_run) begin
            r_rem <= ge ? rem_sub[PB_W-1:0] : rem_sh[PB_W-1:0];
            r_dq  <= {r_dq[PA_W-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_quo  = r_dq;
    assign o_done = r_done;

endmodule

@@ sv/jmse_sqrt.sv @@
// bit-pair floor square root of a 64-bit value, one result bit per cycle
module jmse_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [jmse_pkg::PB_W-1:0]     i_val,
    output logic [jmse_pkg::ROOT_W-1:0]   o_root,
    output logic                          o_done
);
    import jmse_pkg::*;

    logic [PB_W-1:0] r_v;
    logic [PB_W-1:0] r_res;
    logic [PB_W-1:0] r_one;
    logic [4:0]      r_cnt;
    logic            r_run;
    logic            r_done;

    logic [PB_W-1:0] trial;

    assign trial = r_res + r_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && (r_cnt == '0);
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_cnt == '0)) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_res <= '0;
            r_one <= PB_W'(1) << (PB_W - 2);
            r_cnt <= '1;
        end else if (r_run) begin
            if (r_v >= trial) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_one;
            end else begin
                r_res <= r_res >> 1;
            end
            r_one <= r_one >> 2;
            r_cnt <= r_cnt - 5'd1;
        end
    end

    assign o_root = r_res[ROOT_W-1:0];
    assign o_done = r_done;

endmodule

@@ sv/jackknife_mean_std_error.sv @@
// jackknife estimate, standard error and z-score over a run of Q16.16 items
// a non-last replicate item in modes 0/1 runs the 8 partial products of the shared multiplier,
//   a ratio-mode pair is only buffered and added to the totals; a last item runs up to
//   4 multiplies, a variance divide, a root and a z divide
// ratio mode adds a divide and a square per buffered pair at the last item, plus one estimate divide
// the result strobe lasts one cycle and cannot be stalled; busy is high until it has passed
// reset (synchronous, active low) clears mode, accumulators, counts and flags; buffers are not
module jackknife_mean_std_error #(
    parameter int MAX_ITEMS = jmse_pkg::MAX_ITEMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // mode register write
    input  logic               i_mode_we,
    input  logic [1:0]         i_mode_wdata,
    // item transaction
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_value_a,
    input  logic signed [31:0] i_value_b,
    input  logic               i_last,
    // result transaction
    output logic               o_valid,
    output logic signed [31:0] o_estimate,
    output logic [1:0]         o_estimate_state,
    output logic [30:0]        o_std_error,
    output logic [1:0]         o_std_state,
    output logic signed [31:0] o_z_score,
    output logic [1:0]         o_z_state,
    output logic [10:0]        o_rep_count,
    output logic               o_saturated
);
    import jmse_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W = $clog2(MAX_ITEMS);

    // control state
    t_state            r_state, n_state;
    logic [1:0]        r_mode, n_mode;
    logic [ACC_W-1:0]  r_sum, n_sum;       // signed replicate sum
    logic [ACC_W-1:0]  r_sq, n_sq;         // saturating square sum
    logic [TOT_W-1:0]  r_tx, n_tx;         // signed x total
    logic [TOT_W-1:0]  r_ty, n_ty;         // signed y total
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_nan, n_nan;
    logic              r_inf, n_inf;
    logic              r_s2full, n_s2full;
    logic              r_clip, n_clip;

    // working registers
    logic [IDX_W-1:0]  r_j, n_j;
    logic [31:0]       r_rep, n_rep;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [NUM_W-1:0]  r_den, n_den;
    t_dsel             r_dsel, n_dsel;
    logic [31:0]       r_est, n_est;
    logic [1:0]        r_est_st, n_est_st;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [30:0]       r_std, n_std;
    logic [1:0]        r_std_st, n_std_st;
    logic [31:0]       r_z, n_z;
    logic [1:0]        r_z_st, n_z_st;
    logic [PA_W-1:0]   r_pa, n_pa;
    logic [PA_W-1:0]   r_pb, n_pb;

    // pair buffers for ratio mode
    logic [31:0] mem_x [MAX_ITEMS];
    logic [31:0] mem_y [MAX_ITEMS];
    logic [31:0] r_rd_x;
    logic [31:0] r_rd_y;
    logic        mem_we;

    // shared units
    logic              mul_start;
    logic [PA_W-1:0]   mul_a;
    logic [PB_W-1:0]   mul_b;
    logic [PA_W-1:0]   mul_prod;
    logic              mul_done;
    logic              div_start;
    logic [PA_W-1:0]   div_num;
    logic [PB_W-1:0]   div_den;
    logic [PA_W-1:0]   div_quo;
    logic              div_done;
    logic              sqrt_start;
    logic [PB_W-1:0]   sqrt_val;
    logic [ROOT_W-1:0] sqrt_root;
    logic              sqrt_done;

    // item decode
    logic              acc_item;
    logic              is_ratio;
    logic              has_room;
    logic [32:0]       diff;
    logic              diff_clip;
    logic [31:0]       rep_in;

    // quotient post-processing
    logic              dq_fire;
    logic [1:0]        dq_st;
    logic [31:0]       dq_val;
    logic              dq_clip;
    logic              q_neg;
    logic              last_j;
    logic [ACC_W:0]    sq_sum;
    logic [PA_W:0]     pa_sub;
    logic [CNT_W-1:0]  j_next;

    jmse_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (mul_prod),
        .o_done  (mul_done)
    );

    jmse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    jmse_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_val   (sqrt_val),
        .o_root  (sqrt_root),
        .o_done  (sqrt_done)
    );

    assign busy     = (r_state != S_IDLE);
    assign acc_item = start && (r_state == S_IDLE);
    assign is_ratio = (r_mode == MODE_RATIO);
    assign has_room = (r_cnt < CNT_W'(MAX_ITEMS));
    assign mem_we   = acc_item && is_ratio && has_room;

    // mode 1 difference, saturated to Q16.16
    assign diff = {i_value_a[31], i_value_a} - {i_value_b[31], i_value_b};
    always_comb begin
        diff_clip = 1'b0;
        rep_in    = i_value_a;
        if (r_mode == MODE_DIFF) begin
            if (diff[32] != diff[31]) begin
                diff_clip = 1'b1;
                rep_in    = diff[32] ? Q_MIN : Q_MAX;
            end else begin
                rep_in = diff[31:0];
            end
        end
    end

    assign j_next = CNT_W'(r_j) + CNT_W'(1);
    assign last_j = (j_next == r_cnt);
    assign sq_sum = {1'b0, r_sq} + {1'b0, mul_prod[ACC_W-1:0]};
    assign pa_sub = {1'b0, r_pa} - {1'b0, r_pb};
    assign q_neg  = r_num[NUM_W-1] ^ r_den[NUM_W-1];

    // quotient result: divide by zero specials or saturated finite quotient
    always_comb begin
        dq_fire = 1'b0;
        dq_st   = ST_FIN;
        dq_val  = '0;
        dq_clip = 1'b0;
        if (r_state == S_DQ && r_den == '0) begin
            dq_fire = 1'b1;
            if (r_num == '0) begin
                dq_st  = ST_NAN;
                dq_val = '0;
            end else if (r_num[NUM_W-1]) begin
                dq_st  = ST_NINF;
                dq_val = Q_MIN;
            end else begin
                dq_st  = ST_PINF;
                dq_val = Q_MAX;
            end
        end else if (r_state == S_DQW && div_done) begin
            dq_fire = 1'b1;
            if (q_neg) begin
                if ((|div_quo[PA_W-1:32]) || (div_quo[31] && (|div_quo[30:0]))) begin
                    dq_clip = 1'b1;
                    dq_val  = Q_MIN;
                end else begin
                    dq_val = ~div_quo[31:0] + 32'd1;
                end
            end else begin
                if (|div_quo[PA_W-1:31]) begin
                    dq_clip = 1'b1;
                    dq_val  = Q_MAX;
                end else begin
                    dq_val = div_quo[31:0];
                end
            end
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_sum    = r_sum;
        n_sq     = r_sq;
        n_tx     = r_tx;
        n_ty     = r_ty;
        n_cnt    = r_cnt;
        n_nan    = r_nan;
        n_inf    = r_inf;
        n_s2full = r_s2full;
        n_clip   = r_clip;
        n_j      = r_j;
        n_rep    = r_rep;
        n_num    = r_num;
        n_den    = r_den;
        n_dsel   = r_dsel;
        n_est    = r_est;
        n_est_st = r_est_st;
        n_root   = r_root;
        n_std    = r_std;
        n_std_st = r_std_st;
        n_z      = r_z;
        n_z_st   = r_z_st;
        n_pa     = r_pa;
        n_pb     = r_pb;

        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        sqrt_start = 1'b0;
        sqrt_val   = '0;

        case (r_state)
            S_IDLE: begin
                if (acc_item) begin
                    if (is_ratio) begin
                        if (has_room) begin
                            n_tx  = r_tx + {{(TOT_W-32){i_value_a[31]}}, i_value_a};
                            n_ty  = r_ty + {{(TOT_W-32){i_value_b[31]}}, i_value_b};
                            n_cnt = r_cnt + CNT_W'(1);
                        end else begin
                            n_clip = 1'b1;
                        end
                        if (i_last) begin
                            n_j     = '0;
                            n_state = S_RREAD;
                        end
                    end else begin
                        if (diff_clip) begin
                            n_clip = 1'b1;
                        end
                        if (!i_last) begin
                            if (has_room) begin
                                n_rep     = rep_in;
                                n_cnt     = r_cnt + CNT_W'(1);
                                mul_start = 1'b1;
                                mul_a     = PA_W'(mag32(rep_in));
                                mul_b     = PB_W'(mag32(rep_in));
                                n_state   = S_RSQ;
                            end else begin
                                n_clip = 1'b1;
                            end
                        end else begin
                            n_est    = rep_in;
                            n_est_st = ST_FIN;
                            n_state  = S_STD;
                        end
                    end
                end
            end
            // add a replicate and its square
            S_RSQ: begin
                if (mul_done) begin
                    n_sum = r_sum + {{(ACC_W-32){r_rep[31]}}, r_rep};
                    if (sq_sum[ACC_W]) begin
                        n_sq     = '1;
                        n_s2full = 1'b1;
                    end else begin
                        n_sq = sq_sum[ACC_W-1:0];
                    end
                    if (is_ratio) begin
                        if (last_j) begin
                            n_num   = {{(NUM_W-TOT_W){r_tx[TOT_W-1]}}, r_tx};
                            n_den   = {{(NUM_W-TOT_W){r_ty[TOT_W-1]}}, r_ty};
                            n_dsel  = DQ_EST;
                            n_state = S_DQ;
                        end else begin
                            n_j     = r_j + IDX_W'(1);
                            n_state = S_RREAD;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RREAD: begin
                n_state = S_RNUM;
            end
            // leave-one-out numerator and denominator
            S_RNUM: begin
                n_num   = {{(NUM_W-TOT_W){r_tx[TOT_W-1]}}, r_tx}
                        - {{(NUM_W-32){r_rd_x[31]}}, r_rd_x};
                n_den   = {{(NUM_W-TOT_W){r_ty[TOT_W-1]}}, r_ty}
                        - {{(NUM_W-32){r_rd_y[31]}}, r_rd_y};
                n_dsel  = DQ_REP;
                n_state = S_DQ;
            end
            S_DQ: begin
                if (r_den != '0) begin
                    div_start = 1'b1;
                    div_num   = PA_W'({mag50(r_num), 16'b0});
                    div_den   = PB_W'(mag50(r_den));
                    n_state   = S_DQW;
                end
            end
            S_DQW: begin
                // finished by the quotient dispatch below
            end
            S_STD: begin
                if (r_cnt == '0 || r_nan) begin
                    n_std_st = ST_NAN;
                    n_std    = '0;
                    n_state  = S_ZSEL;
                end else if (r_inf) begin
                    n_std_st = ST_PINF;
                    n_std    = Q_MAX[30:0];
                    n_state  = S_ZSEL;
                end else if (r_s2full) begin
                    n_root  = '1;
                    n_state = S_STDFIN;
                end else begin
                    mul_start = 1'b1;
                    mul_a     = PA_W'(r_sq);
                    mul_b     = PB_W'(r_cnt);
                    n_state   = S_MA;
                end
            end
            // n * S2
            S_MA: begin
                if (mul_done) begin
                    n_pa      = mul_prod;
                    mul_start = 1'b1;
                    mul_a     = PA_W'(mag64(r_sum));
                    mul_b     = mag64(r_sum);
                    n_state   = S_MB;
                end
            end
            // S * S
            S_MB: begin
                if (mul_done) begin
                    n_pb    = mul_prod;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (pa_sub[PA_W]) begin
                    n_root  = '0;
                    n_state = S_STDFIN;
                end else begin
                    mul_start = 1'b1;
                    mul_a     = pa_sub[PA_W-1:0];
                    mul_b     = PB_W'(r_cnt) - PB_W'(1);
                    n_state   = S_MP;
                end
            end
            // times (n - 1)
            S_MP: begin
                if (mul_done) begin
                    n_pa      = mul_prod;
                    mul_start = 1'b1;
                    mul_a     = PA_W'(r_cnt);
                    mul_b     = PB_W'(r_cnt);
                    n_state   = S_MN;
                end
            end
            // divide by n * n
            S_MN: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    div_num   = r_pa;
                    div_den   = mul_prod[PB_W-1:0];
                    n_state   = S_VDIV;
                end
            end
            S_VDIV: begin
                if (div_done) begin
                    sqrt_start = 1'b1;
                    sqrt_val   = div_quo[PB_W-1:0];
                    n_state    = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sqrt_done) begin
                    n_root  = sqrt_root;
                    n_state = S_STDFIN;
                end
            end
            S_STDFIN: begin
                n_std_st = ST_FIN;
                if (r_s2full) begin
                    n_clip = 1'b1;
                end
                if (r_root[ROOT_W-1]) begin
                    n_std  = Q_MAX[30:0];
                    n_clip = 1'b1;
                end else begin
                    n_std = r_root[30:0];
                end
                n_state = S_ZSEL;
            end
            S_ZSEL: begin
                if (r_est_st == ST_NAN || r_std_st == ST_NAN) begin
                    n_z_st  = ST_NAN;
                    n_z     = '0;
                    n_state = S_OUT;
                end else if (r_std_st == ST_PINF) begin
                    n_z_st  = (r_est_st == ST_FIN) ? ST_FIN : ST_NAN;
                    n_z     = '0;
                    n_state = S_OUT;
                end else if (r_est_st != ST_FIN) begin
                    n_z_st  = r_est_st;
                    n_z     = r_est;
                    n_state = S_OUT;
                end else begin
                    n_num   = {{(NUM_W-32){r_est[31]}}, r_est};
                    n_den   = NUM_W'(r_root);
                    n_dsel  = DQ_Z;
                    n_state = S_DQ;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // quotient dispatch
        if (dq_fire) begin
            if (dq_clip) begin
                n_clip = 1'b1;
            end
            case (r_dsel)
                DQ_REP: begin
                    if (dq_st == ST_FIN) begin
                        n_rep     = dq_val;
                        mul_start = 1'b1;
                        mul_a     = PA_W'(mag32(dq_val));
                        mul_b     = PB_W'(mag32(dq_val));
                        n_state   = S_RSQ;
                    end else begin
                        if (dq_st == ST_NAN) begin
                            n_nan = 1'b1;
                        end else begin
                            n_inf = 1'b1;
                        end
                        if (last_j) begin
                            n_num   = {{(NUM_W-TOT_W){r_tx[TOT_W-1]}}, r_tx};
                            n_den   = {{(NUM_W-TOT_W){r_ty[TOT_W-1]}}, r_ty};
                            n_dsel  = DQ_EST;
                            n_state = S_DQ;
                        end else begin
                            n_j     = r_j + IDX_W'(1);
                            n_state = S_RREAD;
                        end
                    end
                end
                DQ_EST: begin
                    n_est    = dq_val;
                    n_est_st = dq_st;
                    n_state  = S_STD;
                end
                DQ_Z: begin
                    n_z     = dq_val;
                    n_z_st  = dq_st;
                    n_state = S_OUT;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end

        // end of run or mode write clears the run
        if (r_state == S_OUT || i_mode_we) begin
            n_sum    = '0;
            n_sq     = '0;
            n_tx     = '0;
            n_ty     = '0;
            n_cnt    = '0;
            n_nan    = 1'b0;
            n_inf    = 1'b0;
            n_s2full = 1'b0;
            n_clip   = 1'b0;
        end
        if (i_mode_we) begin
            n_mode = i_mode_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_PLAIN;
            r_sum    <= '0;
            r_sq     <= '0;
            r_tx     <= '0;
            r_ty     <= '0;
            r_cnt    <= '0;
            r_nan    <= 1'b0;
            r_inf    <= 1'b0;
            r_s2full <= 1'b0;
            r_clip   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_sum    <= n_sum;
            r_sq     <= n_sq;
            r_tx     <= n_tx;
            r_ty     <= n_ty;
            r_cnt    <= n_cnt;
            r_nan    <= n_nan;
            r_inf    <= n_inf;
            r_s2full <= n_s2full;
            r_clip   <= n_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j      <= n_j;
        r_rep    <= n_rep;
        r_num    <= n_num;
        r_den    <= n_den;
        r_dsel   <= n_dsel;
        r_est    <= n_est;
        r_est_st <= n_est_st;
        r_root   <= n_root;
        r_std    <= n_std;
        r_std_st <= n_std_st;
        r_z      <= n_z;
        r_z_st   <= n_z_st;
        r_pa     <= n_pa;
        r_pb     <= n_pb;
    end

    // pair buffers: write at the fill count, registered read at the pass index
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_x[r_cnt[IDX_W-1:0]] <= i_value_a;
            mem_y[r_cnt[IDX_W-1:0]] <= i_value_b;
        end
        r_rd_x <= mem_x[r_j];
        r_rd_y <= mem_y[r_j];
    end

    // result transaction, one cycle in the output state
    assign o_valid          = (r_state == S_OUT);
    assign o_estimate       = r_est;
    assign o_estimate_state = r_est_st;
    assign o_std_error      = r_std;
    assign o_std_state      = r_std_st;
    assign o_z_score        = r_z;
    assign o_z_state        = r_z_st;
    assign o_rep_count      = 11'(r_cnt);
    assign o_saturated      = r_clip;

endmodule

@@ sv/jmse_chk.sv @@
// port-level checks for the jackknife standard error block, bound to the top level
module jmse_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_last,
    input logic        o_valid,
    input logic [1:0]  o_std_state,
    input logic [30:0] o_std_error
);
    import jmse_pkg::*;

    // a result transaction is a single-cycle strobe and frees the block
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!o_valid && !busy))
        else $error("result strobe longer than one cycle or block still busy");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result shown while block idle");

    // an item that does not close the run never yields a result next cycle
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last) |=> !o_valid)
        else $error("result after a non-last item");

    a_std_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_std_state != ST_NINF)
                     && ((o_std_state != ST_NAN) || (o_std_error == '0))))
        else $error("bad standard error state or fill");

endmodule

bind jackknife_mean_std_error jmse_chk u_jmse_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_last      (i_last),
    .o_valid     (o_valid),
    .o_std_state (o_std_state),
    .o_std_error (o_std_error)
);

@@ dv/tb_top.sv @@
// self-checking testbench for the jackknife estimate / standard error / z-score block
`timescale 1ns / 1ps

module tb_top;
    import jmse_pkg::*;

    localparam int BUF_DEPTH   = 1024;
    localparam int QUIET_WAIT  = 400;     // quiet wait before a mode write and before the end of the test
    localparam int SHORT_ITEMS = 300;

    // entries of the stimulus queue: an item, a mode write, a drain pause or an idling change
    typedef enum logic [1:0] {K_ITEM, K_MODE, K_DRAIN, K_PHASE} t_entry_kind;

    typedef struct {
        t_entry_kind kind;
        logic [31:0] a;
        logic [31:0] b;
        logic        last;
        logic [1:0]  mode;
        int          idle_pct;
    } t_entry;

    typedef struct {
        logic [31:0] est;
        logic [1:0]  est_st;
        logic [30:0] std_err;
        logic [1:0]  std_st;
        logic [31:0] z;
        logic [1:0]  z_st;
        logic [10:0] reps;
        logic        sat;
    } t_jk_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_mode_we = 1'b0;
    logic [1:0]         i_mode_wdata = '0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] i_value_a = '0;
    logic signed [31:0] i_value_b = '0;
    logic               i_last = 1'b0;
    logic               o_valid;
    logic signed [31:0] o_estimate;
    logic [1:0]         o_estimate_state;
    logic [30:0]        o_std_error;
    logic [1:0]         o_std_state;
    logic signed [31:0] o_z_score;
    logic [1:0]         o_z_state;
    logic [10:0]        o_rep_count;
    logic               o_saturated;

    jackknife_mean_std_error uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mode_we        (i_mode_we),
        .i_mode_wdata     (i_mode_wdata),
        .start            (start),
        .busy             (busy),
        .i_value_a        (i_value_a),
        .i_value_b        (i_value_b),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .o_estimate       (o_estimate),
        .o_estimate_state (o_estimate_state),
        .o_std_error      (o_std_error),
        .o_std_state      (o_std_state),
        .o_z_score        (o_z_score),
        .o_z_state        (o_z_state),
        .o_rep_count      (o_rep_count),
        .o_saturated      (o_saturated)
    );

    always #5 i_clk = ~i_clk;

    t_entry     stim_q[$];
    t_jk_result expected_q[$];
    int         fail_count = 0;

    // ---------------------------------------------------------------------
    // predictor state: mode register, pair buffers and running accumulators
    // ---------------------------------------------------------------------
    logic [1:0]  mode_q;
    logic [31:0] pair_x[BUF_DEPTH];
    logic [31:0] pair_y[BUF_DEPTH];
    longint      rep_sum;
    logic [63:0] rep_sq_sum;
    longint      col_x;
    longint      col_y;
    int          item_cnt;
    logic [1:0]  odd_reps;      // bit0: some replicate was NaN, bit1: some was infinite
    bit          sq_pinned;     // square sum stuck at its maximum
    bit          clip_pending;

    function automatic logic [63:0] abs64(input longint v);
        abs64 = v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic void clear_run();
        rep_sum      = 0;
        rep_sq_sum   = '0;
        col_x        = 0;
        col_y        = 0;
        item_cnt     = 0;
        odd_reps     = '0;
        sq_pinned    = 0;
        clip_pending = 0;
    endfunction

    function automatic void add_replicate(input longint r);
        logic [63:0] sq;
        sq = abs64(r) * abs64(r);
        rep_sum += r;
        if (rep_sq_sum > ~sq) begin
            rep_sq_sum = '1;
            sq_pinned  = 1;
        end else begin
            rep_sq_sum += sq;
        end
    endfunction

    // Q16.16 quotient truncated toward zero, x/0 gives an infinity or NaN
    function automatic logic [1:0] q16_divide(input longint num, input longint den,
                                              output longint val, inout bit clip);
        logic [63:0] q;
        if (den == 0) begin
            if (num > 0) begin
                val = 64'sd2147483647;
                return ST_PINF;
            end
            if (num < 0) begin
                val = -64'sd2147483648;
                return ST_NINF;
            end
            val = 0;
            return ST_NAN;
        end
        q = (abs64(num) << 16) / abs64(den);
        if ((num < 0) != (den < 0)) begin
            if (q > 64'd2147483648) begin
                q    = 64'd2147483648;
                clip = 1;
            end
            val = -longint'(q);
        end else begin
            if (q > 64'd2147483647) begin
                q    = 64'd2147483647;
                clip = 1;
            end
            val = longint'(q);
        end
        return ST_FIN;
    endfunction

    // floor square root of floor((n*S2 - S*S)*(n-1)/n^2), all in Q32.32
    function automatic logic [63:0] variance_root(input int unsigned n);
        logic [255:0] lhs;
        logic [255:0] rhs;
        logic [255:0] vq;
        logic [63:0]  v;
        logic [63:0]  r;
        logic [127:0] t;
        if (sq_pinned)
            return 64'hFFFF_FFFF;
        lhs = 256'(rep_sq_sum) * 256'(n);
        rhs = 256'(abs64(rep_sum)) * 256'(abs64(rep_sum));
        if (lhs < rhs)
            return 64'd0;
        vq = ((lhs - rhs) * 256'(n - 1)) / (256'(n) * 256'(n));
        v  = vq[63:0];
        r  = '0;
        for (int k = 31; k >= 0; k--) begin
            t = 128'(r | (64'd1 << k));
            if (t * t <= 128'(v))
                r |= 64'd1 << k;
        end
        return r;
    endfunction

    // one accepted item: update the run, and on a last item queue the result
    function automatic void predict_item(input logic [31:0] a_in, input logic [31:0] b_in,
                                         input logic last_in);
        longint      a;
        longint      b;
        longint      r;
        longint      est;
        longint      z;
        longint      rv;
        longint      stdv;
        logic [63:0] root;
        logic [1:0]  est_st;
        logic [1:0]  std_st;
        logic [1:0]  z_st;
        logic [1:0]  rs;
        bit          clip;
        int          n;
        t_jk_result  res;
        a    = longint'(signed'(a_in));
        b    = longint'(signed'(b_in));
        est  = 0;
        z    = 0;
        stdv = 0;
        root = '0;
        if (mode_q == MODE_RATIO) begin
            if (item_cnt < BUF_DEPTH) begin
                pair_x[item_cnt] = a_in;
                pair_y[item_cnt] = b_in;
                col_x += a;
                col_y += b;
                item_cnt++;
            end else begin
                clip_pending = 1;
            end
        end else begin
            r = a;
            if (mode_q == MODE_DIFF) begin
                r = a - b;
                if (r > 64'sd2147483647) begin
                    r = 64'sd2147483647;
                    clip_pending = 1;
                end
                if (r < -64'sd2147483648) begin
                    r = -64'sd2147483648;
                    clip_pending = 1;
                end
            end
            if (!last_in) begin
                if (item_cnt < BUF_DEPTH) begin
                    add_replicate(r);
                    item_cnt++;
                end else begin
                    clip_pending = 1;
                end
                return;
            end
            est = r;
        end
        if (!last_in)
            return;

        clip = clip_pending;
        n    = item_cnt;
        if (mode_q == MODE_RATIO) begin
            // leave-one-out ratios, special ones only mark the flags
            for (int j = 0; j < item_cnt; j++) begin
                rs = q16_divide(col_x - longint'(signed'(pair_x[j])),
                                col_y - longint'(signed'(pair_y[j])), rv, clip);
                if (rs == ST_NAN)
                    odd_reps[0] = 1'b1;
                else if (rs != ST_FIN)
                    odd_reps[1] = 1'b1;
                else
                    add_replicate(rv);
            end
            est_st = q16_divide(col_x, col_y, est, clip);
        end else begin
            est_st = ST_FIN;
        end

        if (n == 0 || odd_reps[0]) begin
            std_st = ST_NAN;
        end else if (odd_reps[1]) begin
            std_st = ST_PINF;
            stdv   = 64'sd2147483647;
        end else begin
            std_st = ST_FIN;
            root   = variance_root(n);
            if (sq_pinned)
                clip = 1;
            stdv = longint'(root);
            if (root > 64'd2147483647) begin
                stdv = 64'sd2147483647;
                clip = 1;
            end
        end

        if (est_st == ST_NAN || std_st == ST_NAN) begin
            z_st = ST_NAN;
        end else if (std_st == ST_PINF) begin
            z_st = (est_st == ST_FIN) ? ST_FIN : ST_NAN;
        end else if (est_st != ST_FIN) begin
            z_st = est_st;
            z    = est;
        end else begin
            // z uses the root before it is clipped to 31 bits
            z_st = q16_divide(est, longint'(root), z, clip);
        end

        res.est     = est[31:0];
        res.est_st  = est_st;
        res.std_err = stdv[30:0];
        res.std_st  = std_st;
        res.z       = z[31:0];
        res.z_st    = z_st;
        res.reps    = n[10:0];
        res.sat     = clip;
        expected_q.push_back(res);
        clear_run();
    endfunction

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------
    function automatic void push_item(input logic [31:0] a, input logic [31:0] b,
                                      input logic last_in);
        t_entry e;
        e.kind = K_ITEM;
        e.a = a;
        e.b = b;
        e.last = last_in;
        e.mode = '0;
        e.idle_pct = 0;
        stim_q.push_back(e);
    endfunction

    function automatic void push_ctrl(input t_entry_kind kind, input logic [1:0] mode_val,
                                      input int pct);
        t_entry e;
        e.kind = kind;
        e.a = '0;
        e.b = '0;
        e.last = 1'b0;
        e.mode = mode_val;
        e.idle_pct = pct;
        stim_q.push_back(e);
    endfunction

    // mostly small Q16.16 values so results stay finite, with extremes mixed in
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3, 4:    return $urandom;
            default: return 32'(signed'($urandom_range(0, 40)) - 20) << 16
                            | 32'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // driver: one item in flight on the start/busy handshake
    // ---------------------------------------------------------------------
    bit     in_flight = 0;
    bit     rst_done  = 0;
    int     idle_pct  = 0;
    int     quiet_cnt = 0;
    t_entry cur;

    always @(posedge i_clk) begin
        logic we;
        we = 1'b0;
        if (rst_done) begin
            if (in_flight && start && !busy) begin
                predict_item(cur.a, cur.b, cur.last);
                in_flight = 0;
            end
            if (!in_flight && stim_q.size() > 0) begin
                case (stim_q[0].kind)
                    K_PHASE: begin
                        idle_pct = stim_q[0].idle_pct;
                        void'(stim_q.pop_front());
                    end
                    K_MODE: begin
                        // the block must be fully idle before the register moves
                        if (expected_q.size() == 0 && !busy)
                            quiet_cnt++;
                        else
                            quiet_cnt = 0;
                        if (quiet_cnt >= QUIET_WAIT) begin
                            we = 1'b1;
                            i_mode_wdata <= stim_q[0].mode;
                            mode_q = stim_q[0].mode;
                            clear_run();
                            quiet_cnt = 0;
                            void'(stim_q.pop_front());
                        end
                    end
                    K_DRAIN: begin
                        if (expected_q.size() == 0)
                            void'(stim_q.pop_front());
                    end
                    default: begin
                        if ($urandom_range(0, 99) >= idle_pct) begin
                            cur = stim_q.pop_front();
                            i_value_a <= cur.a;
                            i_value_b <= cur.b;
                            i_last    <= cur.last;
                            in_flight = 1;
                        end
                    end
                endcase
            end
            start <= in_flight;
        end
        i_mode_we <= we;
    end

    // ---------------------------------------------------------------------
    // monitor: every strobed result against the oldest prediction
    // ---------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_jk_result e;
        if (rst_done && o_valid === 1'b1) begin
            if (expected_q.size() == 0) begin
                $error("result transaction with no prediction pending");
                fail_count++;
            end else begin
                e = expected_q.pop_front();
                check_field("estimate", e.est, o_estimate);
                check_field("estimate_state", 32'(e.est_st), 32'(o_estimate_state));
                check_field("std_error", 32'(e.std_err), 32'(o_std_error));
                check_field("std_state", 32'(e.std_st), 32'(o_std_state));
                check_field("z_score", e.z, o_z_score);
                check_field("z_state", 32'(e.z_st), 32'(o_z_state));
                check_field("rep_count", 32'(e.reps), 32'(o_rep_count));
                check_field("saturated", 32'(e.sat), 32'(o_saturated));
            end
        end
    end

    // ---------------------------------------------------------------------
    // sequence: reset, directed runs, long runs, random phases, drain
    // ---------------------------------------------------------------------
    initial begin
        int short_cnt;
        int run_len;
        int phase;
        int pcts[4];
        logic [1:0] m;
        pcts = '{0, 64, 0, 10};

        mode_q = MODE_PLAIN;
        clear_run();

        // plain mode: empty replicate set, extremes, square sum pinned
        push_item(32'h0001_0000, 32'h0, 1'b1);
        push_item(32'h7FFF_FFFF, 32'h0, 1'b0);
        push_item(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        push_item(32'h0000_0001, 32'h0, 1'b1);
        for (int k = 0; k < 4; k++)
            push_item(32'h8000_0000, 32'h0, 1'b0);
        push_item(32'h0002_0000, 32'h0, 1'b1);
        // difference mode: differences out of range both ways
        push_ctrl(K_MODE, MODE_DIFF, 0);
        push_item(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        push_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        push_item(32'h0003_0000, 32'h0001_0000, 1'b0);
        push_item(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        // ratio mode: zero total gives infinities and NaN
        push_ctrl(K_MODE, MODE_RATIO, 0);
        push_item(32'h0, 32'h0, 1'b1);
        push_item(32'h0001_0000, 32'h0001_0000, 1'b0);
        push_item(32'h0, 32'hFFFF_0000, 1'b1);
        push_item(32'hFFFF_0000, 32'h0001_0000, 1'b0);
        push_item(32'h0, 32'hFFFF_0000, 1'b1);
        push_item(32'h0002_0000, 32'h0001_0000, 1'b0);
        push_item(32'h0001_0000, 32'h0002_0000, 1'b0);
        push_item(32'h7FFF_FFFF, 32'h0000_0001, 1'b1);
        push_ctrl(K_DRAIN, 2'd0, 0);

        // full buffer in ratio mode
        for (int k = 0; k < BUF_DEPTH + 2; k++)
            push_item(32'($urandom_range(0, 20)) << 16, 32'($urandom_range(1, 20)) << 16,
                      k == BUF_DEPTH + 1);

        // random runs, idling phase and mode change every so often
        short_cnt = 0;
        phase     = 0;
        while (short_cnt < SHORT_ITEMS) begin
            m = (phase % 3 == 0) ? MODE_PLAIN : (phase % 3 == 1) ? MODE_DIFF : MODE_RATIO;
            if (phase > 6)
                m = 2'($urandom_range(0, 2));
            push_ctrl(K_PHASE, 2'd0, pcts[phase % 4]);
            push_ctrl(K_MODE, m, 0);
            for (int run = 0; run < 12; run++) begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(0, 12);
                for (int k = 0; k < run_len; k++)
                    push_item(pick_value(), pick_value(), 1'b0);
                push_item(pick_value(), pick_value(), 1'b1);
                short_cnt += run_len + 1;
                if (run == 5)
                    push_ctrl(K_DRAIN, 2'd0, 0);
            end
            // now and then leave a run open so the mode write has to drop it
            if ($urandom_range(0, 2) == 0) begin
                for (int k = 0; k < 3; k++)
                    push_item(pick_value(), pick_value(), 1'b0);
                short_cnt += 3;
            end
            phase++;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1;

        wait (stim_q.size() == 0 && !in_flight);
        wait (expected_q.size() == 0);
        repeat (QUIET_WAIT) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $error("%0d predicted results never arrived", expected_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
sv/jmse_pkg.sv
sv/jmse_mul.sv
sv/jmse_div.sv
sv/jmse_sqrt.sv
sv/jackknife_mean_std_error.sv
sv/jmse_chk.sv
dv/tb_top.sv
